>>> rtl/vcmm_pkg.sv
// Package for the velocity command mode mapper.
// Holds the pipeline item type, mode and register codes, the arctangent table and clamps.
// Has no dependencies.
`default_nettype none

package vcmm_pkg;

	localparam int NUM_STEPS = 24;
	localparam int CORDIC_STEPS = 20;
	localparam int DEADBAND_RAW = 6;
	localparam int DEADBAND_SQ = 42;
	localparam int MAX_ACK_ANGLE = 45752;
	localparam int ROUND_BIAS = 8192;

	typedef enum logic [1:0] {
		MODE_STOP = 2'd0,
		MODE_OBLIQUE = 2'd1,
		MODE_SPIN = 2'd2,
		MODE_ACKERMANN = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		REG_COMMAND_HOLD = 3'd0,
		REG_WHEEL_BASE = 3'd1,
		REG_SPEED_LIMIT = 3'd2,
		REG_YAW_RATE_LIMIT = 3'd3,
		REG_OBLIQUE_STEER_LIMIT = 3'd4,
		REG_ACKERMANN_STEER_LIMIT = 3'd5,
		REG_MIN_TURN_RADIUS = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		mode_t mode;
		logic signed [23:0] vx;
		logic signed [23:0] wz;
		logic vx_neg;
		logic ang_neg;
		logic y_zero;
		logic signed [50:0] cx;
		logic signed [50:0] cy;
		logic signed [32:0] cz;
		logic [47:0] rem;
		logic [48:0] res;
	} item_t;

	// Arctangent of 2^-idx in Q2.30 radians.
	function automatic logic [31:0] atan_entry(input int idx);
		case (idx)
			0: return 32'd843314857;
			1: return 32'd497837829;
			2: return 32'd263043837;
			3: return 32'd133525159;
			4: return 32'd67021687;
			5: return 32'd33543516;
			6: return 32'd16775851;
			7: return 32'd8388437;
			8: return 32'd4194283;
			9: return 32'd2097149;
			10: return 32'd1048576;
			11: return 32'd524288;
			12: return 32'd262144;
			13: return 32'd131072;
			14: return 32'd65536;
			15: return 32'd32768;
			16: return 32'd16384;
			17: return 32'd8192;
			18: return 32'd4096;
			19: return 32'd2048;
			default: return 32'd0;
		endcase
	endfunction

	function automatic logic signed [23:0] clamp_speed(input logic signed [25:0] v,
			input logic [22:0] lim);
		logic signed [25:0] l;
		l = $signed({3'b000, lim});
		if (v > l) begin
			return l[23:0];
		end else if (v < -l) begin
			return 24'(-l);
		end else begin
			return v[23:0];
		end
	endfunction

	function automatic logic signed [17:0] clamp_steer(input logic signed [18:0] v,
			input logic [16:0] lim);
		logic signed [18:0] l;
		l = $signed({2'b00, lim});
		if (v > l) begin
			return l[17:0];
		end else if (v < -l) begin
			return 18'(-l);
		end else begin
			return v[17:0];
		end
	endfunction

endpackage

`default_nettype wire

>>> rtl/vcmm_iter.sv
// One pipeline stage of the shared square root and vectoring CORDIC.
// Each stage resolves one root digit and, in the first stages, one rotation.
// Depends on vcmm_pkg.
`default_nettype none

module vcmm_iter #(
	parameter int STEP = 0
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic advance,
	input wire logic valid_i,
	input wire vcmm_pkg::item_t item_i,
	output logic valid_o,
	output vcmm_pkg::item_t item_o
);

	localparam logic [48:0] BITV = 49'(1) << (46 - 2 * STEP);
	localparam logic signed [32:0] ATAN = $signed({1'b0, vcmm_pkg::atan_entry(STEP)});

	logic valid_s1;
	vcmm_pkg::item_t item_s1;
	vcmm_pkg::item_t nxt;
	logic [48:0] trial;
	logic signed [50:0] xs;
	logic signed [50:0] ys;

	always_comb begin
		nxt = item_i;
		trial = item_i.res + BITV;
		if ({1'b0, item_i.rem} >= trial) begin
			nxt.rem = item_i.rem - trial[47:0];
			nxt.res = (item_i.res >> 1) + BITV;
		end else begin
			nxt.res = item_i.res >> 1;
		end
		xs = item_i.cx >>> STEP;
		ys = item_i.cy >>> STEP;
		if (STEP < vcmm_pkg::CORDIC_STEPS) begin
			if (!item_i.cy[50]) begin
				nxt.cx = item_i.cx + ys;
				nxt.cy = item_i.cy - xs;
				nxt.cz = item_i.cz + ATAN;
			end else begin
				nxt.cx = item_i.cx - ys;
				nxt.cy = item_i.cy + xs;
				nxt.cz = item_i.cz - ATAN;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			item_s1 <= nxt;
		end
	end

	assign valid_o = valid_s1;
	assign item_o = item_s1;

endmodule

`default_nettype wire

>>> rtl/velocity_command_mode_mapper_top.sv
// Top level of the velocity command mode mapper.
// Holds the configuration registers, the entry and exit stages and the iteration chain.
// Depends on vcmm_pkg and vcmm_iter.
`default_nettype none

// Each command passes through three entry stages (magnitude,
// products, mode choice), 24 stages of the square root whose first 20 also run the
// arctangent CORDIC, and two exit stages (rounding, clamping). One request is taken
// every cycle; a stall on the result side halts the whole pipeline. Requests that
// arrive while command_hold is set are taken and give no result.
module velocity_command_mode_mapper_top (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [2:0] cfg_index,
	input wire logic [22:0] cfg_data,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic signed [23:0] lin_x,
	input wire logic signed [23:0] lin_y,
	input wire logic signed [23:0] yaw_rate,
	output logic out_valid,
	input wire logic out_stall,
	output logic [1:0] drive_mode,
	output logic signed [23:0] speed_out,
	output logic signed [17:0] steer_out,
	output logic signed [23:0] spin_rate_out
);

	localparam int N = vcmm_pkg::NUM_STEPS;

	logic command_hold_q;
	logic [18:0] wheel_base_q;
	logic [22:0] speed_limit_q;
	logic [22:0] yaw_rate_limit_q;
	logic [16:0] oblique_steer_limit_q;
	logic [16:0] ackermann_steer_limit_q;
	logic [22:0] min_turn_radius_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			command_hold_q <= 1'b0;
			wheel_base_q <= 19'd32768;
			speed_limit_q <= 23'd98304;
			yaw_rate_limit_q <= 23'd65536;
			oblique_steer_limit_q <= 17'd102944;
			ackermann_steer_limit_q <= 17'd45753;
			min_turn_radius_q <= 23'd32768;
		end else if (cfg_we) begin
			case (vcmm_pkg::cfg_reg_t'(cfg_index))
				vcmm_pkg::REG_COMMAND_HOLD: command_hold_q <= cfg_data[0];
				vcmm_pkg::REG_WHEEL_BASE: wheel_base_q <= cfg_data[18:0];
				vcmm_pkg::REG_SPEED_LIMIT: speed_limit_q <= cfg_data;
				vcmm_pkg::REG_YAW_RATE_LIMIT: yaw_rate_limit_q <= cfg_data;
				vcmm_pkg::REG_OBLIQUE_STEER_LIMIT: oblique_steer_limit_q <= cfg_data[16:0];
				vcmm_pkg::REG_ACKERMANN_STEER_LIMIT:
					ackermann_steer_limit_q <= cfg_data[16:0];
				vcmm_pkg::REG_MIN_TURN_RADIUS: min_turn_radius_q <= cfg_data;
				default: ;
			endcase
		end
	end

	logic advance;
	assign advance = !out_valid || !out_stall;
	assign in_stall = !advance;

	// Stage 1: magnitudes.
	logic valid_s1;
	logic signed [23:0] vx_s1, vy_s1, wz_s1;
	logic [23:0] ax_s1, ay_s1, aw_s1;

	// Stage 2: products and deadband flags.
	logic valid_s2;
	logic signed [23:0] vx_s2, vy_s2, wz_s2;
	logic [23:0] ax_s2;
	logic has_vx_s2, has_vy_s2, has_wz_s2;
	logic [47:0] sqx_s2, sqy_s2;
	logic [46:0] spin_rhs_s2;
	logic [42:0] lever_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= in_valid && !command_hold_q;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			vx_s1 <= lin_x;
			vy_s1 <= lin_y;
			wz_s1 <= yaw_rate;
			ax_s1 <= lin_x[23] ? 24'(-lin_x) : lin_x;
			ay_s1 <= lin_y[23] ? 24'(-lin_y) : lin_y;
			aw_s1 <= yaw_rate[23] ? 24'(-yaw_rate) : yaw_rate;
			vx_s2 <= vx_s1;
			vy_s2 <= vy_s1;
			wz_s2 <= wz_s1;
			ax_s2 <= ax_s1;
			has_vx_s2 <= ax_s1 > 24'(vcmm_pkg::DEADBAND_RAW);
			has_vy_s2 <= ay_s1 > 24'(vcmm_pkg::DEADBAND_RAW);
			has_wz_s2 <= aw_s1 > 24'(vcmm_pkg::DEADBAND_RAW);
			sqx_s2 <= 48'(ax_s1) * 48'(ax_s1);
			sqy_s2 <= 48'(ay_s1) * 48'(ay_s1);
			spin_rhs_s2 <= 47'(min_turn_radius_q) * 47'(aw_s1);
			lever_s2 <= 43'(wheel_base_q) * 43'(aw_s1);
		end
	end

	// Stage 3: mode choice and set-up of the iteration chain.
	logic [47:0] sq;
	logic has_tr, spin_cmp, vx_neg;
	logic signed [24:0] vy_f;
	vcmm_pkg::mode_t mode;
	vcmm_pkg::item_t entry;

	always_comb begin
		sq = sqx_s2 + sqy_s2;
		has_tr = sq > 48'(vcmm_pkg::DEADBAND_SQ);
		spin_cmp = 47'({ax_s2, 16'd0}) < spin_rhs_s2;
		vx_neg = vx_s2[23];
		vy_f = vx_neg ? -25'(vy_s2) : 25'(vy_s2);
		if (!has_tr && !has_wz_s2) begin
			mode = vcmm_pkg::MODE_STOP;
		end else if (has_vy_s2) begin
			mode = vcmm_pkg::MODE_OBLIQUE;
		end else if (has_wz_s2 && (!has_vx_s2 || spin_cmp)) begin
			mode = vcmm_pkg::MODE_SPIN;
		end else begin
			mode = vcmm_pkg::MODE_ACKERMANN;
		end
		entry.mode = mode;
		entry.vx = vx_s2;
		entry.wz = wz_s2;
		entry.vx_neg = vx_neg;
		entry.ang_neg = vx_s2[23] != wz_s2[23];
		entry.cz = '0;
		entry.rem = sq;
		entry.res = '0;
		if (mode == vcmm_pkg::MODE_OBLIQUE) begin
			entry.cx = 51'({ax_s2, 24'd0});
			entry.cy = 51'(vy_f) <<< 24;
			entry.y_zero = vy_f == '0;
		end else begin
			entry.cx = 51'({ax_s2, 22'd0});
			entry.cy = 51'({lever_s2, 5'd0});
			entry.y_zero = lever_s2 == '0 || !(has_vx_s2 && has_wz_s2);
		end
	end

	logic valid_s3;
	vcmm_pkg::item_t item_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (advance) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			item_s3 <= entry;
		end
	end

	logic valid_c [0:N];
	vcmm_pkg::item_t item_c [0:N];

	assign valid_c[0] = valid_s3;
	assign item_c[0] = item_s3;

	for (genvar k = 0; k < N; k++) begin : g_iter
		vcmm_iter #(
			.STEP(k)
		) u_iter (
			.clk(clk),
			.arst_n(arst_n),
			.advance(advance),
			.valid_i(valid_c[k]),
			.item_i(item_c[k]),
			.valid_o(valid_c[k + 1]),
			.item_o(item_c[k + 1])
		);
	end

	// Stage 4: root rounding, angle rounding, Ackermann cap and sign.
	vcmm_pkg::item_t fin;
	logic [24:0] mag;
	logic signed [18:0] ang, ack_a;
	logic signed [25:0] speed_pre;
	logic signed [18:0] steer_pre;

	always_comb begin
		fin = item_c[N];
		mag = fin.res[24:0] + 25'({1'b0, fin.rem} > fin.res);
		ang = fin.y_zero ? '0 : 19'((fin.cz + 33'sd8192) >>> 14);
		ack_a = (ang > 19'sd45752) ? 19'sd45752 : ang;
		if (fin.ang_neg) begin
			ack_a = -ack_a;
		end
		if (fin.mode == vcmm_pkg::MODE_OBLIQUE) begin
			steer_pre = ang;
			speed_pre = fin.vx_neg ? -$signed(26'(mag)) : $signed(26'(mag));
		end else begin
			steer_pre = ack_a;
			speed_pre = 26'(fin.vx);
		end
	end

	logic valid_s4;
	vcmm_pkg::mode_t mode_s4;
	logic signed [25:0] speed_s4;
	logic signed [18:0] steer_s4;
	logic signed [23:0] wz_s4;

	// Stage 5: clamps and field selection, the output register.
	logic valid_s5;
	logic [1:0] mode_s5;
	logic signed [23:0] speed_s5, spin_s5;
	logic signed [17:0] steer_s5;
	logic [16:0] steer_lim;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else if (advance) begin
			valid_s4 <= valid_c[N];
			valid_s5 <= valid_s4;
		end
	end

	assign steer_lim = (mode_s4 == vcmm_pkg::MODE_OBLIQUE) ?
		oblique_steer_limit_q : ackermann_steer_limit_q;

	always_ff @(posedge clk) begin
		if (advance) begin
			mode_s4 <= fin.mode;
			speed_s4 <= speed_pre;
			steer_s4 <= steer_pre;
			wz_s4 <= fin.wz;
			mode_s5 <= mode_s4;
			case (mode_s4)
				vcmm_pkg::MODE_OBLIQUE, vcmm_pkg::MODE_ACKERMANN: begin
					speed_s5 <= vcmm_pkg::clamp_speed(speed_s4, speed_limit_q);
					steer_s5 <= vcmm_pkg::clamp_steer(steer_s4, steer_lim);
					spin_s5 <= '0;
				end
				vcmm_pkg::MODE_SPIN: begin
					speed_s5 <= '0;
					steer_s5 <= '0;
					spin_s5 <= vcmm_pkg::clamp_speed(26'(wz_s4), yaw_rate_limit_q);
				end
				default: begin
					speed_s5 <= '0;
					steer_s5 <= '0;
					spin_s5 <= '0;
				end
			endcase
		end
	end

	assign out_valid = valid_s5;
	assign drive_mode = mode_s5;
	assign speed_out = speed_s5;
	assign steer_out = steer_s5;
	assign spin_rate_out = spin_s5;

endmodule

`default_nettype wire
